// ----- design/tpps_pkg.sv -----
// Shared constants and types for the timer prescaler period search core.
`default_nettype none

package tpps_pkg;

    localparam int CLK_W          = 32;
    localparam int FREQ_W         = 16;
    localparam int PERIOD_BITS    = 16;
    localparam int PERIOD_OUT_W   = 16;
    localparam int SEL_W          = 3;
    localparam int STATUS_W       = 2;
    localparam int NUM_DIV        = 7;
    localparam int BITS_PER_STAGE = 4;
    localparam int NUM_STAGES     = CLK_W / BITS_PER_STAGE;

    localparam logic [CLK_W-1:0] CORE_CLOCK_RESET = 32'd32000000;

    // Upper bound on clocks/prescaler: the period (quotient minus one) must fit.
    localparam logic [CLK_W:0] QUOT_LIMIT = (CLK_W + 1)'(64'd1 << PERIOD_BITS);

    // Prescalers 1, 2, 4, 8, 64, 256, 1024 expressed as right shifts.
    localparam int DIV_SHIFT [NUM_DIV] = '{0, 1, 2, 3, 6, 8, 10};

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ZERO_FREQ = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_FIT    = 2'd2;

    localparam logic [SEL_W-1:0] SEL_NONE = 3'd0;

    // One stage of the radix-2 restoring divider pipeline.
    typedef struct packed {
        logic              zero_freq;
        logic [FREQ_W-1:0] divisor;
        logic [FREQ_W-1:0] rem;
        logic [CLK_W-1:0]  acc;    // remaining dividend bits above, quotient bits below
    } div_stage_t;

endpackage : tpps_pkg

`default_nettype wire

// ----- design/timer_prescaler_period_search_core.sv -----
// Top level: pipelined clocks-per-tick divider and prescaler selection.
//
//  Channel   Ports                                         Direction  Transfer when
//  --------  --------------------------------------------  ---------  ---------------------------
//  command   start, wanted_freq_hz, busy                   in         rising edge, start && !busy
//  result    done, clock_select, period_value, status      out        rising edge ending done cycle
//  config    cfg_write_en, cfg_write_data                  in         rising edge, cfg_write_en
//
// Stages: a command enters an input stage, then eight divider stages that each
// retire four quotient bits of core_clock_reg / wanted_freq_hz, then the output
// register, loaded together with done; the result transfers at the edge that
// ends the done cycle. Fully pipelined: a command is taken every cycle, busy low.
// Reset: rst_n clears all valid bits and loads core_clock_reg with 32000000.
// Stalls: the receiver cannot hold results off and the pipeline never stalls.
`default_nettype none

module timer_prescaler_period_search_core
    import tpps_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    // command
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic [FREQ_W-1:0]       wanted_freq_hz,
    // configuration
    input  wire logic                    cfg_write_en,
    input  wire logic [CLK_W-1:0]        cfg_write_data,
    // result
    output logic                         done,
    output logic [SEL_W-1:0]             clock_select,
    output logic [PERIOD_OUT_W-1:0]      period_value,
    output logic [STATUS_W-1:0]          status
);

    logic [CLK_W-1:0] core_clock_reg;

    logic       valid_reg [0:NUM_STAGES];
    div_stage_t stage_reg [0:NUM_STAGES];
    div_stage_t stage_next [1:NUM_STAGES];

    logic                    done_reg;
    logic [SEL_W-1:0]        clock_select_reg;
    logic [PERIOD_OUT_W-1:0] period_value_reg;
    logic [STATUS_W-1:0]     status_reg;

    logic [SEL_W-1:0]        clock_select_next;
    logic [PERIOD_OUT_W-1:0] period_value_next;
    logic [STATUS_W-1:0]     status_next;

    logic accept;

    // The pipeline advances every cycle, so a command is always taken.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Configuration register; the user must write it only while the pipeline is empty, the block does not enforce this.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            core_clock_reg <= CORE_CLOCK_RESET;
        end
        else if (cfg_write_en)
        begin
            core_clock_reg <= cfg_write_data;
        end
    end

    // Valid bits travel with the data through every stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= NUM_STAGES; s++)
            begin
                valid_reg[s] <= 1'b0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= accept;
            for (int s = 1; s <= NUM_STAGES; s++)
            begin
                valid_reg[s] <= valid_reg[s-1];
            end
            done_reg <= valid_reg[NUM_STAGES];
        end
    end

    // Input stage: load the dividend and divisor, flag a zero frequency.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_reg[0].zero_freq <= (wanted_freq_hz == '0);
            stage_reg[0].divisor   <= wanted_freq_hz;
            stage_reg[0].rem       <= '0;
            stage_reg[0].acc       <= core_clock_reg;
        end
    end

    // Divider stages: each shifts in four dividend bits and produces four
    // quotient bits by restoring subtraction against the 16-bit divisor.
    genvar gs;
    generate
        for (gs = 1; gs <= NUM_STAGES; gs++)
        begin : g_div
            always_comb
            begin
                logic [FREQ_W:0] trial;
                logic            qbit;
                stage_next[gs] = stage_reg[gs-1];
                for (int b = 0; b < BITS_PER_STAGE; b++)
                begin
                    trial = {stage_next[gs].rem, stage_next[gs].acc[CLK_W-1]};
                    qbit  = (trial >= {1'b0, stage_next[gs].divisor});
                    if (qbit)
                    begin
                        trial = trial - {1'b0, stage_next[gs].divisor};
                    end
                    stage_next[gs].rem = trial[FREQ_W-1:0];
                    stage_next[gs].acc = {stage_next[gs].acc[CLK_W-2:0], qbit};
                end
            end

            always_ff @(posedge clk)
            begin
                if (valid_reg[gs-1])
                begin
                    stage_reg[gs] <= stage_next[gs];
                end
            end
        end
    endgenerate

    // Selection: clocks mod prescaler is the error, and it never shrinks as
    // the prescaler grows, so the first prescaler whose quotient fits also has
    // the least error (ties go to the smaller one). Scan from the top down so
    // the lowest fitting index wins.
    always_comb
    begin
        logic [CLK_W-1:0] clocks;
        logic [CLK_W-1:0] quot;
        logic [CLK_W-1:0] quot_win;
        logic             fit_any;
        logic [SEL_W-1:0] sel_win;
        clocks   = stage_reg[NUM_STAGES].acc;
        quot_win = '0;
        fit_any  = 1'b0;
        sel_win  = SEL_NONE;
        for (int k = NUM_DIV - 1; k >= 0; k--)
        begin
            quot = clocks >> DIV_SHIFT[k];
            if ((quot != '0) && ({1'b0, quot} <= QUOT_LIMIT))
            begin
                fit_any  = 1'b1;
                quot_win = quot;
                sel_win  = SEL_W'(k + 1);
            end
        end

        if (stage_reg[NUM_STAGES].zero_freq)
        begin
            clock_select_next = SEL_NONE;
            period_value_next = '0;
            status_next       = STATUS_ZERO_FREQ;
        end
        else if (!fit_any)
        begin
            clock_select_next = SEL_NONE;
            period_value_next = '0;
            status_next       = STATUS_NO_FIT;
        end
        else
        begin
            clock_select_next = sel_win;
            period_value_next = quot_win[PERIOD_OUT_W-1:0] - PERIOD_OUT_W'(1);
            status_next       = STATUS_OK;
        end
    end

    // Output register: capture each result alongside done and hold it until the next one.
    always_ff @(posedge clk)
    begin
        if (valid_reg[NUM_STAGES])
        begin
            clock_select_reg <= clock_select_next;
            period_value_reg <= period_value_next;
            status_reg       <= status_next;
        end
    end

    assign done         = done_reg;
    assign clock_select = clock_select_reg;
    assign period_value = period_value_reg;
    assign status       = status_reg;

endmodule : timer_prescaler_period_search_core

`default_nettype wire

// ----- bench/tb_timer_prescaler_period_search_core.sv -----
// Self-checking testbench for the timer prescaler and period search core.
`default_nettype none

module tb_timer_prescaler_period_search_core;
    import tpps_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Margin waited out after draining, longer than the core's pipeline.
    localparam int SETTLE_CYCLES = 12;
    // Largest period the timer register accepts.
    localparam logic [63:0] PERIOD_MAX = (64'd1 << PERIOD_BITS) - 64'd1;
    localparam int NUM_PHASES = 4;
    localparam int CLOCKS_PER_PHASE = 3;
    localparam int ITEMS_PER_CLOCK = 75;

    // One predicted timer setting, in the order of the result ports.
    typedef struct packed {
        logic [SEL_W-1:0]        sel;
        logic [PERIOD_OUT_W-1:0] period;
        logic [STATUS_W-1:0]     stat;
    } tick_setting_t;

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic [FREQ_W-1:0]       wanted_freq_hz;
    logic                    cfg_write_en;
    logic [CLK_W-1:0]        cfg_write_data;
    logic                    done;
    logic [SEL_W-1:0]        clock_select;
    logic [PERIOD_OUT_W-1:0] period_value;
    logic [STATUS_W-1:0]     status;

    // Copy of the core clock register as the predictor sees it.
    logic [CLK_W-1:0] model_core_hz = CORE_CLOCK_RESET;
    // Settings predicted for accepted requests, oldest first.
    tick_setting_t    pending_settings[$];
    int               mismatches = 0;
    // Chance in percent that the sender extends its idle spell, drawn anew each time.
    int               idle_pct = 0;

    timer_prescaler_period_search_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .wanted_freq_hz (wanted_freq_hz),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .done           (done),
        .clock_select   (clock_select),
        .period_value   (period_value),
        .status         (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Prescaler ratio for search position k: 1, 2, 4, 8, 64, 256, 1024.
    function automatic logic [CLK_W-1:0] prescaler_ratio(input int k);
        case (k)
            0:       return 32'd1;
            1:       return 32'd2;
            2:       return 32'd4;
            3:       return 32'd8;
            4:       return 32'd64;
            5:       return 32'd256;
            default: return 32'd1024;
        endcase
    endfunction

    // Predict the clock select, period and status for one wanted frequency
    // under the current core clock.
    function automatic tick_setting_t search_prescaler(input logic [FREQ_W-1:0] freq);
        tick_setting_t best;
        logic [CLK_W-1:0] clocks;
        logic [CLK_W-1:0] ratio;
        logic [CLK_W-1:0] quot;
        logic [CLK_W-1:0] slack;
        logic [CLK_W-1:0] best_slack;
        bit               found;
        best.sel    = SEL_NONE;
        best.period = '0;
        best.stat   = STATUS_OK;
        best_slack  = '1;
        found       = 1'b0;
        if (freq == '0)
        begin
            best.stat = STATUS_ZERO_FREQ;
            return best;
        end
        clocks = model_core_hz / {16'd0, freq};
        for (int k = 0; k < NUM_DIV; k++)
        begin
            ratio = prescaler_ratio(k);
            quot  = clocks / ratio;
            // Skip a prescaler that underflows or leaves too wide a period.
            if (quot == '0)
                continue;
            if (64'(quot - 32'd1) > PERIOD_MAX)
                continue;
            slack = clocks - quot * ratio;
            // Strictly less: on a tie the smaller prescaler keeps the slot.
            if (!found || slack < best_slack)
            begin
                found       = 1'b1;
                best_slack  = slack;
                best.sel    = SEL_W'(k + 1);
                best.period = PERIOD_OUT_W'(quot - 32'd1);
            end
        end
        if (!found)
        begin
            best.sel    = SEL_NONE;
            best.period = '0;
            best.stat   = STATUS_NO_FIT;
        end
        return best;
    endfunction

    // Compare each result against the oldest prediction. Outputs are read in
    // the active region of the edge, so they hold the values of the done cycle.
    always @(posedge clk)
    begin : check_results
        tick_setting_t want;
        if (rst_n && done === 1'b1)
        begin
            if (pending_settings.size() == 0)
            begin
                $display("%0t: result with no request pending: sel %0d period %0d status %0d",
                         $realtime, clock_select, period_value, status);
                mismatches++;
            end
            else
            begin
                want = pending_settings.pop_front();
                if (clock_select !== want.sel)
                begin
                    $display("%0t: clock_select expected %0d actual %0d",
                             $realtime, want.sel, clock_select);
                    mismatches++;
                end
                if (period_value !== want.period)
                begin
                    $display("%0t: period_value expected %0d actual %0d",
                             $realtime, want.period, period_value);
                    mismatches++;
                end
                if (status !== want.stat)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $realtime, want.stat, status);
                    mismatches++;
                end
            end
        end
    end

    // Hold start low for a random number of cycles, per idle_pct.
    task automatic pause_sender();
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Present one request and wait for its transfer. Start is left high so
    // back-to-back requests keep it asserted without a glitch.
    task automatic send_freq(input logic [FREQ_W-1:0] freq);
        pause_sender();
        start          <= 1'b1;
        wanted_freq_hz <= freq;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        pending_settings.push_back(search_prescaler(freq));
    endtask

    // Stop sending and wait until every predicted result has come back,
    // then let the pipeline settle.
    task automatic drain_results();
        start <= 1'b0;
        while (pending_settings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Program the core clock register; only done with the pipeline empty.
    task automatic write_core_clock(input logic [CLK_W-1:0] hz);
        drain_results();
        cfg_write_en   <= 1'b1;
        cfg_write_data <= hz;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        model_core_hz   = hz;
    endtask

    // Zero frequency, the top of the range and alternating bit patterns,
    // all against the reset core clock.
    task automatic test_frequency_extremes();
        send_freq(16'd0);
        send_freq(16'd1);
        send_freq(16'hFFFF);
        send_freq(16'h8000);
        send_freq(16'h5555);
        send_freq(16'hAAAA);
    endtask

    // At 32 MHz these frequencies make each prescaler in turn the first that
    // fits: 500 Hz picks divide by 1, ..., 1 Hz picks divide by 1024.
    // 489 and 488 sit on either side of the divide-by-1 overflow.
    task automatic test_each_prescaler();
        send_freq(16'd500);
        send_freq(16'd300);
        send_freq(16'd200);
        send_freq(16'd100);
        send_freq(16'd10);
        send_freq(16'd2);
        send_freq(16'd1);
        send_freq(16'd489);
        send_freq(16'd488);
    endtask

    // Core clock corners: zero (every candidate underflows), all ones (slow
    // ticks overflow even at divide by 1024), one, and the edges of the
    // divide-by-1 period range where equal error makes the smaller prescaler win.
    task automatic test_core_clock_corners();
        write_core_clock(32'd0);
        send_freq(16'd1);
        send_freq(16'hFFFF);
        write_core_clock(32'hFFFF_FFFF);
        send_freq(16'd1);
        send_freq(16'hFFFF);
        write_core_clock(32'd1);
        send_freq(16'd1);
        send_freq(16'd2);
        write_core_clock(32'd65536);
        send_freq(16'd1);
        write_core_clock(32'd65537);
        send_freq(16'd1);
    endtask

    // Random requests over three core clocks in each of four sender idle phases.
    // Each register write first drains the pipeline, so the sender pauses until
    // all results are back three times per phase.
    task automatic test_random_traffic();
        logic [CLK_W-1:0]    hz;
        logic [FREQ_W-1:0]   freq;
        logic [63:0]         target;
        logic [63:0]         scaled;
        int                  phase_idle [NUM_PHASES];
        phase_idle = '{0, 62, 25, 0};
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            idle_pct = phase_idle[ph];
            for (int c = 0; c < CLOCKS_PER_PHASE; c++)
            begin
                case ($urandom_range(9))
                    0:       hz = 32'hFFFF_FFFF;
                    1:       hz = 32'd0;
                    2, 3:    hz = $urandom;
                    4, 5:    hz = $urandom_range(200000);
                    default: hz = $urandom_range(100000000, 1000000);
                endcase
                write_core_clock(hz);
                for (int n = 0; n < ITEMS_PER_CLOCK; n++)
                begin
                    case ($urandom_range(9))
                        0:       freq = 16'd0;
                        1:       freq = 16'hFFFF;
                        2, 3:    freq = 16'($urandom);
                        4, 5:    freq = 16'($urandom_range(1023, 1));
                        default:
                        begin
                            // Aim clocks per tick at a prescaler's overflow edge.
                            target = 64'(prescaler_ratio($urandom_range(NUM_DIV - 1)))
                                     * (64'd65535 + 64'($urandom_range(2)));
                            scaled = {32'd0, model_core_hz} / target;
                            freq   = (scaled > 64'hFFFF) ? 16'($urandom) : 16'(scaled);
                        end
                    endcase
                    send_freq(freq);
                end
            end
        end
    endtask

    // Run every test in turn, then report.
    initial
    begin
        rst_n          <= 1'b0;
        start          <= 1'b0;
        wanted_freq_hz <= '0;
        cfg_write_en   <= 1'b0;
        cfg_write_data <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_frequency_extremes();
        test_each_prescaler();
        test_core_clock_corners();
        test_random_traffic();

        drain_results();
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Hard stop well beyond the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("%0t: timeout with %0d results still pending",
                 $realtime, pending_settings.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ----- timer_prescaler_period_search_core.f -----
design/tpps_pkg.sv
design/timer_prescaler_period_search_core.sv
bench/tb_timer_prescaler_period_search_core.sv
